// ===== src/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants of the looping sample mixer.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 34;
  localparam int PROD_W     = 33;
  localparam int OP_W       = 3;
  localparam int CH_FIELD_W = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13573;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_APPEND = 3'd1,
    OP_GAIN   = 3'd2,
    OP_PLAY   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // one tick lane entering the multiply-accumulate
  typedef struct packed {
    logic valid;
    logic en;
    logic last;
  } mac_ctl_t;

endpackage

// ===== src/looping_sample_mixer_8ch.sv =====
// ----------------------------------------------------------------------------
// looping_sample_mixer_8ch
// Mixer of looping 16-bit PCM channels with Q15 gains and an exact 34-bit mix.
// ----------------------------------------------------------------------------
// A word on the input carries one operation in tuser: tick, append, set gain,
// set play or clear. Append, gain and play are a read-modify-write of the
// channel's entry in the state RAM, and clear drops the channel's valid bit;
// a tick sweeps the state RAM one channel per cycle, the single state RAM
// read port setting that pace, and puts its mix word on the output. The
// input is ready again in the cycle after the mix reaches the output
// register, even while that word waits for tready, so a new tick is taken
// only once the last tick's mix is in the output register. A mix that finds
// the output register still full holds the input until that word is taken.
// The sample store is a CHANNELS * SAMPLES_PER_CHANNEL word RAM with no
// clearing pass; per-channel state comes out of reset at once through valid
// bits.
module looping_sample_mixer_8ch #(
  parameter int SAMPLES_PER_CHANNEL = 65536,
  parameter int CHANNELS            = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // [2:0] operation
  input  logic [lsm_pkg::OP_W-1:0]           s_tuser_i,
  // [2:0] channel, [18:3] sample, [34:19] gain, [35] play_flag, rest zero
  input  logic [lsm_pkg::IN_DATA_W-1:0]      s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // [33:0] mix, rest zero
  output logic [lsm_pkg::OUT_DATA_W-1:0]     m_tdata_o
);

  localparam int AW = $clog2(CHANNELS * SAMPLES_PER_CHANNEL);

  logic [lsm_pkg::CH_FIELD_W-1:0] channel;
  logic [lsm_pkg::SMP_W-1:0]      sample;
  logic [lsm_pkg::GAIN_W-1:0]     gain;
  logic                           play_flag;

  logic smp_we, smp_re, mac_busy;
  logic [AW-1:0] smp_waddr, smp_raddr;
  logic [lsm_pkg::SMP_W-1:0] smp_wdata, smp_rdata;
  lsm_pkg::mac_ctl_t mac_ctl;
  logic [lsm_pkg::GAIN_W-1:0] mac_gain;
  logic [lsm_pkg::MIX_W-1:0] mix;

  assign channel   = s_tdata_i[2:0];
  assign sample    = s_tdata_i[18:3];
  assign gain      = s_tdata_i[34:19];
  assign play_flag = s_tdata_i[35];

  lsm_ctrl #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
    .CHANNELS            (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .op_i        (s_tuser_i),
    .chan_i      (channel),
    .sample_i    (sample),
    .gain_i      (gain),
    .play_i      (play_flag),
    .mac_busy_i  (mac_busy),
    .smp_we_o    (smp_we),
    .smp_waddr_o (smp_waddr),
    .smp_wdata_o (smp_wdata),
    .smp_re_o    (smp_re),
    .smp_raddr_o (smp_raddr),
    .mac_ctl_o   (mac_ctl),
    .mac_gain_o  (mac_gain)
  );

  lsm_ram #(
    .W     (lsm_pkg::SMP_W),
    .DEPTH (CHANNELS * SAMPLES_PER_CHANNEL)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (smp_waddr),
    .wdata_i (smp_wdata),
    .re_i    (smp_re),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  lsm_mac #(.CHANNELS(CHANNELS)) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .gain_i     (mac_gain),
    .sample_i   (smp_rdata),
    .busy_o     (mac_busy),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .mix_o      (mix)
  );

  assign m_tdata_o = {(lsm_pkg::OUT_DATA_W - lsm_pkg::MIX_W)'(0), mix};

endmodule

// ===== src/lsm_ram.sv =====
// ----------------------------------------------------------------------------
// lsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsm_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                              wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [W-1:0]                              rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsm_ctrl
// Operation sequencer: holds the per-channel state RAM, runs the tick sweep
// (read state, pick sample address, write back position) and the
// read-modify-write of append, gain, play and clear.
// ----------------------------------------------------------------------------
module lsm_ctrl #(
  parameter int SAMPLES_PER_CHANNEL = 65536,
  parameter int CHANNELS            = 8,
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int AW = $clog2(CHANNELS * SAMPLES_PER_CHANNEL)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [lsm_pkg::OP_W-1:0]      op_i,
  input  logic [lsm_pkg::CH_FIELD_W-1:0] chan_i,
  input  logic [lsm_pkg::SMP_W-1:0]     sample_i,
  input  logic [lsm_pkg::GAIN_W-1:0]    gain_i,
  input  logic                          play_i,
  input  logic                          mac_busy_i,
  output logic                          smp_we_o,
  output logic [AW-1:0]                 smp_waddr_o,
  output logic [lsm_pkg::SMP_W-1:0]     smp_wdata_o,
  output logic                          smp_re_o,
  output logic [AW-1:0]                 smp_raddr_o,
  output lsm_pkg::mac_ctl_t             mac_ctl_o,
  output logic [lsm_pkg::GAIN_W-1:0]    mac_gain_o
);

  localparam int PW = $clog2(SAMPLES_PER_CHANNEL);
  localparam int LW = $clog2(SAMPLES_PER_CHANNEL + 1);
  localparam int SW = 1 + lsm_pkg::GAIN_W + PW + LW;

  localparam logic [SW-1:0] ST_RESET = {1'b0, lsm_pkg::GAIN_RESET, PW'(0), LW'(0)};
  localparam logic [SW-1:0] ST_FIRST = {1'b0, lsm_pkg::GAIN_RESET, PW'(0), LW'(1)};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOD   = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic rd_vld_q, rd_vld_d;

  lsm_pkg::op_e op_q, op_d;
  logic [CW-1:0] chan_q, chan_d;
  logic chan_ok_q, chan_ok_d;
  logic [lsm_pkg::SMP_W-1:0] smp_q, smp_d;
  logic [lsm_pkg::GAIN_W-1:0] gain_q, gain_d;
  logic play_q, play_d;

  logic p1_v_q, p1_v_d;
  logic p1_last_q, p1_last_d;
  logic [CW-1:0] p1_ch_q, p1_ch_d;
  lsm_pkg::mac_ctl_t p2_q, p2_d;
  logic [lsm_pkg::GAIN_W-1:0] p2_gain_q, p2_gain_d;

  logic st_we, st_re;
  logic [CW-1:0] st_waddr, st_raddr;
  logic [SW-1:0] st_wdata, st_rdata, cur;

  logic [LW-1:0] cur_len, nxt;
  logic [PW-1:0] cur_pos, pos0;
  logic [lsm_pkg::GAIN_W-1:0] cur_gain, gain_sat;
  logic cur_play, active;

  lsm_ram #(.W(SW), .DEPTH(CHANNELS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign cur      = rd_vld_q ? st_rdata : ST_RESET;
  assign cur_len  = cur[LW-1:0];
  assign cur_pos  = cur[LW +: PW];
  assign cur_gain = cur[LW+PW +: lsm_pkg::GAIN_W];
  assign cur_play = cur[SW-1];

  assign active   = cur_play && (cur_len != '0);
  assign pos0     = (LW'(cur_pos) >= cur_len) ? '0 : cur_pos;
  assign nxt      = ((LW'(pos0) + LW'(1)) >= cur_len) ? '0 : (LW'(pos0) + LW'(1));
  assign gain_sat = (gain_q > lsm_pkg::GAIN_MAX) ? lsm_pkg::GAIN_MAX : gain_q;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    vld_d     = vld_q;
    op_d      = op_q;
    chan_d    = chan_q;
    chan_ok_d = chan_ok_q;
    smp_d     = smp_q;
    gain_d    = gain_q;
    play_d    = play_q;
    p1_v_d    = 1'b0;
    p1_last_d = 1'b0;
    p1_ch_d   = idx_q;
    st_re     = 1'b0;
    st_raddr  = idx_q;
    st_we     = 1'b0;
    st_waddr  = chan_q;
    st_wdata  = cur;
    smp_we_o    = 1'b0;
    smp_waddr_o = AW'(chan_q) * AW'(SAMPLES_PER_CHANNEL) + AW'(cur_len);
    smp_wdata_o = smp_q;
    smp_re_o    = 1'b0;
    smp_raddr_o = AW'(p1_ch_q) * AW'(SAMPLES_PER_CHANNEL) + AW'(pos0);
    p2_d.valid  = p1_v_q;
    p2_d.en     = p1_v_q && active;
    p2_d.last   = p1_last_q;
    p2_gain_d   = cur_gain;

    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          op_d      = lsm_pkg::op_e'(op_i);
          chan_d    = CW'(chan_i);
          chan_ok_d = 32'(chan_i) < CHANNELS;
          smp_d     = sample_i;
          gain_d    = gain_i;
          play_d    = play_i;
          if (lsm_pkg::op_e'(op_i) == lsm_pkg::OP_TICK) begin
            idx_d   = '0;
            state_d = ST_TICK;
          end else begin
            st_re    = 1'b1;
            st_raddr = CW'(chan_i);
            state_d  = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        state_d = ST_IDLE;
        if (chan_ok_q) begin
          unique case (op_q)
            lsm_pkg::OP_APPEND: begin
              if (cur_len == '0) begin
                st_we       = 1'b1;
                st_wdata    = ST_FIRST;
                smp_we_o    = 1'b1;
                vld_d[chan_q] = 1'b1;
              end else if (cur_len < LW'(SAMPLES_PER_CHANNEL)) begin
                st_we       = 1'b1;
                st_wdata    = {cur[SW-1:LW], cur_len + LW'(1)};
                smp_we_o    = 1'b1;
                vld_d[chan_q] = 1'b1;
              end
            end
            lsm_pkg::OP_GAIN: begin
              st_we    = 1'b1;
              st_wdata = {cur_play, gain_sat, cur_pos, cur_len};
              vld_d[chan_q] = 1'b1;
            end
            lsm_pkg::OP_PLAY: begin
              st_we    = 1'b1;
              st_wdata = {play_q, cur_gain, cur_pos, cur_len};
              vld_d[chan_q] = 1'b1;
            end
            lsm_pkg::OP_CLEAR: begin
              vld_d[chan_q] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        st_re     = 1'b1;
        st_raddr  = idx_q;
        p1_v_d    = 1'b1;
        p1_ch_d   = idx_q;
        p1_last_d = (idx_q == CW'(CHANNELS - 1));
        if (idx_q == CW'(CHANNELS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!p1_v_q && !p2_q.valid && !mac_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // tick lane: state data of channel p1_ch_q is here
    if (p1_v_q) begin
      smp_re_o = 1'b1;
      if (active) begin
        st_we    = 1'b1;
        st_waddr = p1_ch_q;
        st_wdata = {cur_play, cur_gain, PW'(nxt), cur_len};
        vld_d[p1_ch_q] = 1'b1;
      end
    end

    rd_vld_d = vld_q[st_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      p1_v_q   <= 1'b0;
      p1_last_q <= 1'b0;
      p2_q     <= '0;
      op_q     <= lsm_pkg::OP_TICK;
      chan_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      vld_q    <= vld_d;
      rd_vld_q <= rd_vld_d;
      p1_v_q   <= p1_v_d;
      p1_last_q <= p1_last_d;
      p2_q     <= p2_d;
      op_q     <= op_d;
      chan_ok_q <= chan_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q    <= chan_d;
    smp_q     <= smp_d;
    gain_q    <= gain_d;
    play_q    <= play_d;
    p1_ch_q   <= p1_ch_d;
    p2_gain_q <= p2_gain_d;
  end

  assign mac_ctl_o  = p2_q;
  assign mac_gain_o = p2_gain_q;

endmodule

// ===== src/lsm_mac.sv =====
// ----------------------------------------------------------------------------
// lsm_mac
// Multiply-accumulate of the tick lane, 34-bit saturation and the output
// word register.
// ----------------------------------------------------------------------------
module lsm_mac #(
  parameter int CHANNELS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsm_pkg::mac_ctl_t            ctl_i,
  input  logic [lsm_pkg::GAIN_W-1:0]   gain_i,
  input  logic [lsm_pkg::SMP_W-1:0]    sample_i,
  output logic                         busy_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [lsm_pkg::MIX_W-1:0]    mix_o
);

  localparam int ACC_W = lsm_pkg::PROD_W + $clog2(CHANNELS) + 1;
  localparam int MW    = lsm_pkg::MIX_W;

  logic signed [lsm_pkg::SMP_W-1:0]  smp;
  logic signed [lsm_pkg::GAIN_W:0]   gn;
  logic signed [lsm_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, sum;
  logic p3_v_q, p3_last_q;
  logic [MW-1:0] res_q, res_d, sat;
  logic res_v_q, res_v_d;
  logic out_v_q, out_v_d;
  logic [MW-1:0] mix_q, mix_d;
  logic take;

  assign smp    = $signed(sample_i);
  assign gn     = $signed({1'b0, gain_i});
  assign prod_d = ctl_i.en ? (lsm_pkg::PROD_W'(smp) * lsm_pkg::PROD_W'(gn)) : '0;
  assign sum    = acc_q + ACC_W'(prod_q);

  always_comb begin
    if ((&sum[ACC_W-1:MW-1]) || !(|sum[ACC_W-1:MW-1])) begin
      sat = sum[MW-1:0];
    end else if (sum[ACC_W-1]) begin
      sat = {1'b1, {(MW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(MW-1){1'b1}}};
    end
  end

  assign take = !out_v_q || m_tready_i;

  always_comb begin
    acc_d   = acc_q;
    res_d   = res_q;
    res_v_d = res_v_q;
    out_v_d = out_v_q;
    mix_d   = mix_q;
    if (take) begin
      out_v_d = res_v_q;
      mix_d   = res_q;
      res_v_d = 1'b0;
    end
    if (p3_v_q) begin
      if (p3_last_q) begin
        res_d   = sat;
        res_v_d = 1'b1;
        acc_d   = '0;
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q    <= 1'b0;
      p3_last_q <= 1'b0;
      acc_q     <= '0;
      res_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      p3_v_q    <= ctl_i.valid;
      p3_last_q <= ctl_i.last;
      acc_q     <= acc_d;
      res_v_q   <= res_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
    mix_q  <= mix_d;
  end

  assign busy_o     = p3_v_q || res_v_q;
  assign m_tvalid_o = out_v_q;
  assign mix_o      = mix_q;

endmodule

// ===== src/lsm_chk.sv =====
// ----------------------------------------------------------------------------
// lsm_chk
// Port-level checks of the looping sample mixer, bound to the top level.
// ----------------------------------------------------------------------------
module lsm_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_o,
  input logic [lsm_pkg::OP_W-1:0]       s_tuser_i,
  input logic                           m_tvalid_o,
  input logic                           m_tready_i,
  input logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata_o
);

  logic tick_acc, other_acc;

  assign tick_acc  = s_tvalid_i && s_tready_o && (s_tuser_i == lsm_pkg::OP_TICK);
  assign other_acc = s_tvalid_i && s_tready_o && (s_tuser_i != lsm_pkg::OP_TICK);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("output word changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !s_tready_o)
    else $error("input ready right after a tick");

  a_other_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_acc |=> !s_tready_o ##1 s_tready_o)
    else $error("channel operation did not take two cycles");

  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> !s_tready_o)
    else $error("mix word appeared outside a tick");

endmodule

bind looping_sample_mixer_8ch lsm_chk u_lsm_chk (.*);

// ===== sim/lsm_mix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsm_mix_checker
// Watches both stream ports of the looping sample mixer, keeps its own copy of
// the channel state, predicts the mix of every tick word and compares each
// output word against the oldest predicted mix.
// ----------------------------------------------------------------------------
module lsm_mix_checker #(
  parameter int SAMPLES_PER_CHANNEL = 65536,
  parameter int CHANNELS            = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [lsm_pkg::OP_W-1:0]       s_tuser_i,
  input  logic [lsm_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                             pending_o,
  output int                             fail_cnt_o
);

  localparam int     MW     = lsm_pkg::MIX_W;
  localparam int     OW     = lsm_pkg::OUT_DATA_W;
  localparam longint MIX_HI = (longint'(1) <<< (MW - 1)) - 1;
  localparam longint MIX_LO = -(longint'(1) <<< (MW - 1));

  bit signed [lsm_pkg::SMP_W-1:0] pcm [CHANNELS][SAMPLES_PER_CHANNEL];
  logic [16:0]                    loop_len [CHANNELS];
  logic [15:0]                    play_pos [CHANNELS];
  logic [lsm_pkg::GAIN_W-1:0]     gain_q15 [CHANNELS];
  logic                           playing  [CHANNELS];

  logic [MW-1:0]              pending_mixes [$];
  logic [MW-1:0]              want_mix;
  logic [2:0]                 w_ch;
  logic [lsm_pkg::SMP_W-1:0]  w_smp;
  logic [lsm_pkg::GAIN_W-1:0] w_gain;
  logic                       w_flag;

  initial fail_cnt_o = 0;

  task automatic report_mismatch(input string what, input logic [MW-1:0] exp_v,
                                 input logic [MW-1:0] got_v);
    $display("%0t ns: %s mismatch, expected %h got %h", $time, what, exp_v, got_v);
    fail_cnt_o++;
  endtask

  function automatic void silence_channel(input int c);
    loop_len[c] = '0;
    play_pos[c] = '0;
    gain_q15[c] = lsm_pkg::GAIN_RESET;
    playing[c]  = 1'b0;
  endfunction

  // one tick: sum over playing, non-empty channels, then advance positions
  function automatic logic [MW-1:0] mix_frame();
    longint acc;
    int     p;
    acc = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (playing[c] && loop_len[c] != 0) begin
        p = (play_pos[c] >= loop_len[c]) ? 0 : int'(play_pos[c]);
        acc += longint'(pcm[c][p]) * longint'(gain_q15[c]);
        p++;
        if (p >= loop_len[c]) p = 0;
        play_pos[c] = p[15:0];
      end
    end
    if (acc > MIX_HI) acc = MIX_HI;
    if (acc < MIX_LO) acc = MIX_LO;
    return acc[MW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) silence_channel(c);
      pending_mixes.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (pending_mixes.size() == 0) begin
          report_mismatch("unexpected mix word", '0, m_tdata_i[MW-1:0]);
        end else begin
          want_mix = pending_mixes.pop_front();
          if (m_tdata_i[MW-1:0] !== want_mix)
            report_mismatch("mix", want_mix, m_tdata_i[MW-1:0]);
          if (m_tdata_i[OW-1:MW] !== '0)
            report_mismatch("mix padding", '0, MW'(m_tdata_i[OW-1:MW]));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        w_ch   = s_tdata_i[2:0];
        w_smp  = s_tdata_i[18:3];
        w_gain = s_tdata_i[34:19];
        w_flag = s_tdata_i[35];
        case (s_tuser_i)
          lsm_pkg::OP_TICK: pending_mixes.push_back(mix_frame());
          lsm_pkg::OP_APPEND: begin
            if (loop_len[w_ch] == 0) begin
              silence_channel(w_ch);
              pcm[w_ch][0] = w_smp;
              loop_len[w_ch] = 17'd1;
            end else if (loop_len[w_ch] < SAMPLES_PER_CHANNEL) begin
              pcm[w_ch][loop_len[w_ch][15:0]] = w_smp;
              loop_len[w_ch]++;
            end
          end
          lsm_pkg::OP_GAIN:
            gain_q15[w_ch] = (w_gain > lsm_pkg::GAIN_MAX) ? lsm_pkg::GAIN_MAX : w_gain;
          lsm_pkg::OP_PLAY:  playing[w_ch] = w_flag;
          lsm_pkg::OP_CLEAR: silence_channel(w_ch);
          default: ;
        endcase
      end
      pending_o <= pending_mixes.size();
    end
  end

endmodule

// ===== sim/tb_looping_sample_mixer_8ch.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_looping_sample_mixer_8ch
// Drives operation words into the looping sample mixer: a directed opening,
// random channel setups with tick bursts under three idling mixes, a long
// output stall, a drain pause and one long loop beside a one-sample loop.
// A checker beside the block predicts and compares every mix word.
// ----------------------------------------------------------------------------
module tb_looping_sample_mixer_8ch;

  localparam int SAMPLES_PER_CHANNEL = 65536;
  localparam int CHANNELS            = 8;
  localparam int RANDOM_WORDS        = 1700;
  localparam int HOLD_CYCLES         = 400;
  localparam int FILL_CH             = 5;
  localparam int FILL_WORDS          = 120;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [lsm_pkg::OP_W-1:0]       s_tuser;
  logic [lsm_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata;
  int                             pending;
  int                             fail_cnt;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int words_sent  = 0;
  bit hold_req    = 1'b0;

  always #6 clk = ~clk;

  looping_sample_mixer_8ch #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
    .CHANNELS           (CHANNELS)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tuser_i (s_tuser),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  lsm_mix_checker #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
    .CHANNELS           (CHANNELS)
  ) u_mix_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tuser_i (s_tuser),
    .s_tdata_i (s_tdata),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .pending_o (pending),
    .fail_cnt_o(fail_cnt)
  );

  // valid stays high between back-to-back words; lowered only on a gap
  task automatic send_word(input logic [lsm_pkg::OP_W-1:0] op, input logic [2:0] ch,
                           input logic [lsm_pkg::SMP_W-1:0] smp,
                           input logic [lsm_pkg::GAIN_W-1:0] g, input logic flag);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, flag, g, smp, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op <= lsm_pkg::OP_CLEAR) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(lsm_pkg::OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [lsm_pkg::SMP_W-1:0] rand_pcm();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [lsm_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return lsm_pkg::GAIN_MAX;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(lsm_pkg::GAIN_MAX));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic build_loop();
    logic [2:0] ch;
    ch = 3'($urandom_range(CHANNELS - 1));
    if ($urandom_range(2) == 0)
      send_word(lsm_pkg::OP_CLEAR, ch, 16'($urandom), 16'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 12))
      send_word(lsm_pkg::OP_APPEND, ch, rand_pcm(), 16'($urandom), 1'($urandom));
    if ($urandom_range(1) == 0)
      send_word(lsm_pkg::OP_GAIN, ch, 16'($urandom), rand_gain(), 1'($urandom));
    send_word(lsm_pkg::OP_PLAY, ch, 16'($urandom), 16'($urandom), $urandom_range(9) != 0);
    repeat ($urandom_range(1, 16)) send_tick();
  endtask

  task automatic full_scale();
    logic [lsm_pkg::SMP_W-1:0] smp;
    smp = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    for (int c = 0; c < CHANNELS; c++) begin
      send_word(lsm_pkg::OP_CLEAR, 3'(c), 16'($urandom), 16'($urandom), 1'($urandom));
      send_word(lsm_pkg::OP_APPEND, 3'(c), smp, 16'($urandom), 1'($urandom));
      send_word(lsm_pkg::OP_GAIN, 3'(c), 16'($urandom), lsm_pkg::GAIN_MAX, 1'($urandom));
      send_word(lsm_pkg::OP_PLAY, 3'(c), 16'($urandom), 16'($urandom), 1'b1);
    end
    repeat (2) send_tick();
  endtask

  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    bit held;
    bit drained;
    held     = 1'b0;
    drained  = 1'b0;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tuser  = '0;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    for (int k = int'(lsm_pkg::OP_CLEAR) + 1; k < (1 << lsm_pkg::OP_W); k++)
      send_word(lsm_pkg::OP_W'(k), 3'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom));
    send_word(lsm_pkg::OP_GAIN, 3'd2, '0, 16'd1000, 1'b0);
    send_word(lsm_pkg::OP_PLAY, 3'd2, '0, '0, 1'b1);
    send_word(lsm_pkg::OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(lsm_pkg::OP_APPEND, 3'd2, 16'h7FFF, '0, 1'b0);
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_PLAY, 3'd2, '0, '0, 1'b1);
    send_word(lsm_pkg::OP_APPEND, 3'd2, 16'h8000, '0, 1'b0);
    send_word(lsm_pkg::OP_GAIN, 3'd2, '0, 16'hFFFF, 1'b0);
    repeat (3) send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_GAIN, 3'd2, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_CLEAR, 3'd2, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_APPEND, 3'd7, 16'h8000, '0, 1'b0);
    send_word(lsm_pkg::OP_GAIN, 3'd7, '0, lsm_pkg::GAIN_MAX, 1'b0);
    send_word(lsm_pkg::OP_PLAY, 3'd7, '0, '0, 1'b1);
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_PLAY, 3'd7, '0, '0, 1'b0);
    send_word(lsm_pkg::OP_TICK, 3'd0, '0, '0, 1'b0);

    // random part
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent < RANDOM_WORDS / 3) begin
        tx_idle_pct = 6;
        rx_idle_pct = 86;
      end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (!drained && words_sent >= RANDOM_WORDS / 2) begin
        wait_drain();
        drained = 1'b1;
      end
      if (!held && words_sent >= 3 * RANDOM_WORDS / 4) begin
        hold_req = 1'b1;
        repeat (40) send_tick();
        held = 1'b1;
      end
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: build_loop();
        9, 10, 11: repeat ($urandom_range(1, 24)) send_tick();
        12, 13: begin
          if ($urandom_range(1))
            send_word(lsm_pkg::OP_GAIN, 3'($urandom), 16'($urandom), rand_gain(),
                      1'($urandom));
          else
            send_word(lsm_pkg::OP_PLAY, 3'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
          send_tick();
        end
        14: full_scale();
        default: repeat ($urandom_range(1, 6))
          send_word(lsm_pkg::OP_W'($urandom), 3'($urandom), rand_pcm(), rand_gain(),
                    1'($urandom));
      endcase
    end

    // one long loop, and a one-sample loop on the neighbor
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_word(lsm_pkg::OP_CLEAR, 3'(FILL_CH), '0, '0, 1'b0);
    send_word(lsm_pkg::OP_CLEAR, 3'(FILL_CH + 1), '0, '0, 1'b0);
    repeat (FILL_WORDS)
      send_word(lsm_pkg::OP_APPEND, 3'(FILL_CH), 16'($urandom), 16'($urandom),
                1'($urandom));
    send_word(lsm_pkg::OP_APPEND, 3'(FILL_CH + 1), 16'h1234, '0, 1'b0);
    send_word(lsm_pkg::OP_GAIN, 3'(FILL_CH), '0, lsm_pkg::GAIN_MAX, 1'b0);
    send_word(lsm_pkg::OP_PLAY, 3'(FILL_CH), '0, '0, 1'b1);
    send_word(lsm_pkg::OP_PLAY, 3'(FILL_CH + 1), '0, '0, 1'b1);
    repeat (6) send_tick();
    s_tvalid <= 1'b0;

    wait_drain();
    repeat (40) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== looping_sample_mixer_8ch.f =====
src/lsm_pkg.sv
src/lsm_ram.sv
src/lsm_ctrl.sv
src/lsm_mac.sv
src/looping_sample_mixer_8ch.sv
src/lsm_chk.sv
sim/lsm_mix_checker.sv
sim/tb_looping_sample_mixer_8ch.sv
